// File: hdl/x86_instruction_encoder_defines.svh
// ----------------------------------------------------------------------------
// x86 instruction encoder assertion macros
// Shared forms for the concurrent checks on the encoder's ports.
// ----------------------------------------------------------------------------
`ifndef X86_INSTRUCTION_ENCODER_DEFINES_SVH
`define X86_INSTRUCTION_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XIE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("x86_instruction_encoder: port check failed");

// The consequent must hold in the cycle after the antecedent.
`define XIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("x86_instruction_encoder: port check failed");

`endif

// File: hdl/xie_pkg.sv
// ----------------------------------------------------------------------------
// x86 instruction encoder package
// Operation and operand codes, encoding forms, byte constants and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xie_pkg;

   localparam logic [4:0] OP_ADD   = 5'd0;
   localparam logic [4:0] OP_CMP   = 5'd1;
   localparam logic [4:0] OP_LEAVE = 5'd2;
   localparam logic [4:0] OP_MOV   = 5'd3;
   localparam logic [4:0] OP_POP   = 5'd4;
   localparam logic [4:0] OP_PUSH  = 5'd5;
   localparam logic [4:0] OP_RET   = 5'd6;
   localparam logic [4:0] OP_SUB   = 5'd7;
   localparam logic [4:0] OP_CALL  = 5'd8;
   localparam logic [4:0] OP_JE    = 5'd9;
   localparam logic [4:0] OP_JMP   = 5'd10;
   localparam logic [4:0] OP_SETE  = 5'd11;
   localparam logic [4:0] OP_SETNE = 5'd12;
   localparam logic [4:0] OP_SETL  = 5'd13;
   localparam logic [4:0] OP_SETG  = 5'd14;
   localparam logic [4:0] OP_SETLE = 5'd15;
   localparam logic [4:0] OP_SETGE = 5'd16;

   localparam logic [1:0] KIND_REG = 2'd0;
   localparam logic [1:0] KIND_IMM = 2'd1;
   localparam logic [1:0] KIND_MEM = 2'd2;
   localparam logic [1:0] KIND_OFF = 2'd3;

   localparam logic [1:0] MOD_DISP8 = 2'd1;
   localparam logic [1:0] MOD_REG   = 2'd3;

   localparam logic [7:0] BYTE_REX_W     = 8'h48;
   localparam logic [7:0] BYTE_REX       = 8'h40;
   localparam logic [7:0] BYTE_REX_B     = 8'h41;
   localparam logic [7:0] BYTE_ALU_IMM8  = 8'h83;
   localparam logic [7:0] BYTE_MOV_IMM   = 8'hb8;
   localparam logic [7:0] BYTE_MOV_LOAD  = 8'h8b;
   localparam logic [7:0] BYTE_MOV_STORE = 8'h89;
   localparam logic [7:0] BYTE_ADD_LOAD  = 8'h03;
   localparam logic [7:0] BYTE_SUB_LOAD  = 8'h2b;
   localparam logic [7:0] BYTE_CMP_LOAD  = 8'h3b;
   localparam logic [7:0] BYTE_ADD_STORE = 8'h01;
   localparam logic [7:0] BYTE_SUB_STORE = 8'h29;
   localparam logic [7:0] BYTE_CMP_STORE = 8'h39;
   localparam logic [7:0] BYTE_LEAVE     = 8'hc9;
   localparam logic [7:0] BYTE_RET       = 8'hc3;
   localparam logic [7:0] BYTE_POP       = 8'h58;
   localparam logic [7:0] BYTE_PUSH      = 8'h50;
   localparam logic [7:0] BYTE_CALL      = 8'he8;
   localparam logic [7:0] BYTE_JE        = 8'h74;
   localparam logic [7:0] BYTE_JMP       = 8'heb;
   localparam logic [7:0] BYTE_TWO_BYTE  = 8'h0f;

   localparam logic [2:0] EXT_ADD = 3'd0;
   localparam logic [2:0] EXT_SUB = 3'd5;
   localparam logic [2:0] EXT_CMP = 3'd7;

   typedef enum logic [3:0] {
      FORM_ALU_MEM,
      FORM_ALU_IMM,
      FORM_ALU_REG,
      FORM_LEAVE,
      FORM_MOV_LOAD,
      FORM_MOV_IMM,
      FORM_MOV_RR,
      FORM_MOV_STORE,
      FORM_PUSHPOP,
      FORM_RET,
      FORM_CALL,
      FORM_JCC,
      FORM_SETCC
   } form_type;

   typedef struct packed {
      logic [4:0]         op;
      logic [1:0]         first_kind;
      logic [3:0]         first_reg;
      logic signed [7:0]  first_disp;
      logic signed [31:0] first_value;
      logic [1:0]         second_kind;
      logic [3:0]         second_reg;
      logic signed [7:0]  second_disp;
      logic signed [31:0] second_value;
   } instr_type;

   // Result of the decode stage: the chosen form and the one data word it needs.
   typedef struct packed {
      logic        ok;
      form_type    form;
      logic [4:0]  op;
      logic [3:0]  r1;
      logic [3:0]  r2;
      logic [31:0] data;
   } dec_info_type;

   // Result of the assembly stage: an optional prefix byte ahead of the body.
   typedef struct packed {
      logic        ok;
      logic        has_prefix;
      logic [7:0]  prefix;
      logic [39:0] body;
      logic [2:0]  body_len;
   } asm_info_type;

   function automatic logic needs_sib(input logic [3:0] base);
      return base[2:0] == 3'd4;
   endfunction

   function automatic logic [7:0] modrm(input logic [1:0] mode, input logic [2:0] reg_field,
                                        input logic [2:0] rm);
      return {mode, reg_field, rm};
   endfunction

   function automatic logic [7:0] setcc_code(input logic [4:0] op);
      logic [7:0] code;
      case (op)
         OP_SETE:  code = 8'h94;
         OP_SETNE: code = 8'h95;
         OP_SETL:  code = 8'h9c;
         OP_SETG:  code = 8'h9f;
         OP_SETLE: code = 8'h9e;
         OP_SETGE: code = 8'h9d;
         default:  code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

// File: hdl/xie_decode.sv
// ----------------------------------------------------------------------------
// Decode stage
// Checks the operand combination, picks the encoding form and its data word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xie_decode
   import xie_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   output logic         up_ready,
   input  instr_type    instr,
   output logic         down_valid,
   input  logic         down_ready,
   output dec_info_type info
);

   logic         valid_ff;
   logic         valid_in;
   dec_info_type info_ff;
   dec_info_type info_in;
   logic [32:0]  jrel;
   logic         jrange;

   assign up_ready   = !valid_ff || down_ready;
   assign valid_in   = up_valid;
   assign down_valid = valid_ff;
   assign info       = info_ff;

   always_comb begin
      info_in      = '0;
      info_in.form = FORM_RET;
      info_in.op   = instr.op;
      info_in.r1   = instr.first_reg;
      info_in.r2   = instr.second_reg;
      // Short branches store rel8; the offset must fit a signed byte after the -2.
      jrel   = {instr.first_value[31], instr.first_value} - 33'd2;
      jrange = (jrel[32:7] == '0) || (jrel[32:7] == '1);
      case (instr.op) inside
         OP_ADD, OP_SUB, OP_CMP: begin
            if (instr.first_kind == KIND_REG) begin
               case (instr.second_kind)
                  KIND_MEM: begin
                     info_in.form = FORM_ALU_MEM;
                     info_in.ok   = !needs_sib(instr.second_reg);
                     info_in.data = {24'h0, instr.second_disp};
                  end
                  KIND_IMM: begin
                     info_in.form = FORM_ALU_IMM;
                     info_in.ok   = !instr.second_value[7];
                     info_in.data = {24'h0, instr.second_value[7:0]};
                  end
                  KIND_REG: begin
                     info_in.form = FORM_ALU_REG;
                     info_in.ok   = 1'b1;
                  end
                  default: info_in.ok = 1'b0;
               endcase
            end
         end
         OP_LEAVE: begin
            info_in.form = FORM_LEAVE;
            info_in.ok   = 1'b1;
         end
         OP_MOV: begin
            if (instr.first_kind == KIND_MEM) begin
               info_in.form = FORM_MOV_STORE;
               info_in.ok   = (instr.second_kind == KIND_REG) && !needs_sib(instr.first_reg);
               info_in.data = {24'h0, instr.first_disp};
            end else if (instr.first_kind == KIND_REG) begin
               case (instr.second_kind)
                  KIND_MEM: begin
                     info_in.form = FORM_MOV_LOAD;
                     info_in.ok   = !needs_sib(instr.second_reg) &&
                                    (instr.second_disp != 8'sh80) &&
                                    (instr.second_disp != 8'sh7f);
                     info_in.data = {24'h0, instr.second_disp};
                  end
                  KIND_IMM: begin
                     info_in.form = FORM_MOV_IMM;
                     info_in.ok   = 1'b1;
                     info_in.data = instr.second_value;
                  end
                  KIND_REG: begin
                     info_in.form = FORM_MOV_RR;
                     info_in.ok   = 1'b1;
                  end
                  default: info_in.ok = 1'b0;
               endcase
            end
         end
         OP_POP, OP_PUSH: begin
            info_in.form = FORM_PUSHPOP;
            info_in.ok   = instr.first_kind == KIND_REG;
         end
         OP_RET: begin
            info_in.form = FORM_RET;
            info_in.ok   = 1'b1;
         end
         OP_CALL: begin
            info_in.form = FORM_CALL;
            info_in.ok   = instr.first_kind == KIND_OFF;
            info_in.data = $unsigned(instr.first_value) - 32'd5;
         end
         OP_JE, OP_JMP: begin
            info_in.form = FORM_JCC;
            info_in.ok   = (instr.first_kind == KIND_OFF) && jrange;
            info_in.data = {24'h0, jrel[7:0]};
         end
         [OP_SETE:OP_SETGE]: begin
            info_in.form = FORM_SETCC;
            info_in.ok   = instr.first_kind == KIND_REG;
         end
         default: info_in.ok = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         info_ff <= info_in;
      end
   end

endmodule

// File: hdl/xie_assemble.sv
// ----------------------------------------------------------------------------
// Assembly stage
// Builds the REX prefix, opcode, ModRM and trailing data bytes for each form.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xie_assemble
   import xie_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   output logic         up_ready,
   input  dec_info_type dec,
   output logic         down_valid,
   input  logic         down_ready,
   output asm_info_type info
);

   logic         valid_ff;
   logic         valid_in;
   asm_info_type info_ff;
   asm_info_type info_in;
   logic [7:0]   rex_load;
   logic [7:0]   rex_store;
   logic [7:0]   alu_load_opc;
   logic [7:0]   alu_store_opc;
   logic [2:0]   alu_ext;

   assign up_ready   = !valid_ff || down_ready;
   assign valid_in   = up_valid;
   assign down_valid = valid_ff;
   assign info       = info_ff;

   // A load puts the first register in ModRM.reg; a store puts the second there.
   assign rex_load  = BYTE_REX_W | {5'b0, dec.r1[3], 1'b0, dec.r2[3]};
   assign rex_store = BYTE_REX_W | {5'b0, dec.r2[3], 1'b0, dec.r1[3]};

   always_comb begin
      case (dec.op)
         OP_SUB: begin
            alu_load_opc  = BYTE_SUB_LOAD;
            alu_store_opc = BYTE_SUB_STORE;
            alu_ext       = EXT_SUB;
         end
         OP_CMP: begin
            alu_load_opc  = BYTE_CMP_LOAD;
            alu_store_opc = BYTE_CMP_STORE;
            alu_ext       = EXT_CMP;
         end
         default: begin
            alu_load_opc  = BYTE_ADD_LOAD;
            alu_store_opc = BYTE_ADD_STORE;
            alu_ext       = EXT_ADD;
         end
      endcase
   end

   always_comb begin
      info_in    = '0;
      info_in.ok = dec.ok;
      case (dec.form)
         FORM_ALU_MEM: begin
            info_in.has_prefix = 1'b1;
            info_in.prefix     = rex_load;
            info_in.body       = {16'h0, dec.data[7:0],
                                  modrm(MOD_DISP8, dec.r1[2:0], dec.r2[2:0]), alu_load_opc};
            info_in.body_len   = 3'd3;
         end
         FORM_ALU_IMM: begin
            info_in.has_prefix = 1'b1;
            info_in.prefix     = BYTE_REX_W | {7'b0, dec.r1[3]};
            info_in.body       = {16'h0, dec.data[7:0],
                                  modrm(MOD_REG, alu_ext, dec.r1[2:0]), BYTE_ALU_IMM8};
            info_in.body_len   = 3'd3;
         end
         FORM_ALU_REG: begin
            info_in.has_prefix = 1'b1;
            info_in.prefix     = rex_store;
            info_in.body       = {24'h0, modrm(MOD_REG, dec.r2[2:0], dec.r1[2:0]),
                                  alu_store_opc};
            info_in.body_len   = 3'd2;
         end
         FORM_LEAVE: begin
            info_in.body     = {32'h0, BYTE_LEAVE};
            info_in.body_len = 3'd1;
         end
         FORM_MOV_LOAD: begin
            info_in.has_prefix = 1'b1;
            info_in.prefix     = rex_load;
            info_in.body       = {16'h0, dec.data[7:0],
                                  modrm(MOD_DISP8, dec.r1[2:0], dec.r2[2:0]), BYTE_MOV_LOAD};
            info_in.body_len   = 3'd3;
         end
         FORM_MOV_IMM: begin
            info_in.has_prefix = dec.r1[3];
            info_in.prefix     = BYTE_REX_B;
            info_in.body       = {dec.data, BYTE_MOV_IMM | {5'b0, dec.r1[2:0]}};
            info_in.body_len   = 3'd5;
         end
         FORM_MOV_RR: begin
            info_in.has_prefix = 1'b1;
            info_in.prefix     = rex_store;
            info_in.body       = {24'h0, modrm(MOD_REG, dec.r2[2:0], dec.r1[2:0]),
                                  BYTE_MOV_STORE};
            info_in.body_len   = 3'd2;
         end
         FORM_MOV_STORE: begin
            info_in.has_prefix = 1'b1;
            info_in.prefix     = rex_store;
            info_in.body       = {16'h0, dec.data[7:0],
                                  modrm(MOD_DISP8, dec.r2[2:0], dec.r1[2:0]), BYTE_MOV_STORE};
            info_in.body_len   = 3'd3;
         end
         FORM_PUSHPOP: begin
            info_in.has_prefix = dec.r1[3];
            info_in.prefix     = BYTE_REX_B;
            info_in.body       = {32'h0, ((dec.op == OP_POP) ? BYTE_POP : BYTE_PUSH) |
                                          {5'b0, dec.r1[2:0]}};
            info_in.body_len   = 3'd1;
         end
         FORM_RET: begin
            info_in.body     = {32'h0, BYTE_RET};
            info_in.body_len = 3'd1;
         end
         FORM_CALL: begin
            info_in.body     = {dec.data, BYTE_CALL};
            info_in.body_len = 3'd5;
         end
         FORM_JCC: begin
            info_in.body     = {24'h0, dec.data[7:0], (dec.op == OP_JE) ? BYTE_JE : BYTE_JMP};
            info_in.body_len = 3'd2;
         end
         FORM_SETCC: begin
            // Byte registers 4 to 7 need a plain REX to mean spl..dil rather than ah..bh.
            info_in.has_prefix = dec.r1[3] || dec.r1[2];
            info_in.prefix     = dec.r1[3] ? BYTE_REX_B : BYTE_REX;
            info_in.body       = {16'h0, modrm(MOD_REG, 3'd0, dec.r1[2:0]),
                                  setcc_code(dec.op), BYTE_TWO_BYTE};
            info_in.body_len   = 3'd3;
         end
         default: info_in.ok = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         info_ff <= info_in;
      end
   end

endmodule

// File: hdl/xie_pack.sv
// ----------------------------------------------------------------------------
// Output stage
// Places the prefix ahead of the body, forms length and status, and holds them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xie_pack
   import xie_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   output logic         up_ready,
   input  asm_info_type asm_info,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [47:0]  rsp_code_bytes,
   output logic [2:0]   rsp_code_length,
   output logic         rsp_status
);

   logic        valid_ff;
   logic        valid_in;
   logic [47:0] bytes_ff;
   logic [47:0] bytes_in;
   logic [2:0]  length_ff;
   logic [2:0]  length_in;
   logic        status_ff;
   logic        status_in;

   assign up_ready = !valid_ff || rsp_ready;
   assign valid_in = up_valid;

   always_comb begin
      if (!asm_info.ok) begin
         bytes_in  = '0;
         length_in = 3'd0;
         status_in = 1'b1;
      end else if (asm_info.has_prefix) begin
         bytes_in  = {asm_info.body, asm_info.prefix};
         length_in = asm_info.body_len + 3'd1;
         status_in = 1'b0;
      end else begin
         bytes_in  = {8'h00, asm_info.body};
         length_in = asm_info.body_len;
         status_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         bytes_ff  <= bytes_in;
         length_ff <= length_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_code_bytes  = bytes_ff;
   assign rsp_code_length = length_ff;
   assign rsp_status      = status_ff;

endmodule

// File: hdl/x86_instruction_encoder.sv
// ----------------------------------------------------------------------------
// x86-64 instruction encoder
// Three-stage pipeline turning one instruction into its encoded bytes.
// ----------------------------------------------------------------------------
// An instruction enters on the req_ channel as an opcode and two operands.
// Each one gives exactly one transfer on the rsp_ channel: up to six bytes,
// first byte in bits 7:0, the byte count, and a status that is set, with
// bytes and count zero, for any unsupported combination or value.
// There are three register stages: a decode stage that checks operands and
// works out branch offsets, an assembly stage that builds prefix, opcode and
// ModRM bytes, and an output register. Throughput is one instruction per
// cycle while the receiver keeps rsp_ready high; the stages hold no state
// between instructions, so each one is independent of the last.
// When the receiver holds rsp_ready low the output register keeps its
// transfer. The ready path runs combinationally back through the stages:
// a stage with an empty slot keeps accepting, and req_ready falls in the same
// cycle once all three stages hold a transfer. Nothing is lost or repeated.
// Synchronous reset empties all three stages; rsp_valid is low after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module x86_instruction_encoder
   import xie_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [4:0]         req_type,
   input  logic [1:0]         req_first_kind,
   input  logic [3:0]         req_first_reg,
   input  logic signed [7:0]  req_first_disp,
   input  logic signed [31:0] req_first_value,
   input  logic [1:0]         req_second_kind,
   input  logic [3:0]         req_second_reg,
   input  logic signed [7:0]  req_second_disp,
   input  logic signed [31:0] req_second_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [47:0]        rsp_code_bytes,
   output logic [2:0]         rsp_code_length,
   output logic               rsp_status
);

   instr_type    instr;
   dec_info_type dec_info;
   asm_info_type asm_info;
   logic         dec_valid;
   logic         asm_valid;
   logic         asm_ready;
   logic         pack_ready;

   assign instr.op           = req_type;
   assign instr.first_kind   = req_first_kind;
   assign instr.first_reg    = req_first_reg;
   assign instr.first_disp   = req_first_disp;
   assign instr.first_value  = req_first_value;
   assign instr.second_kind  = req_second_kind;
   assign instr.second_reg   = req_second_reg;
   assign instr.second_disp  = req_second_disp;
   assign instr.second_value = req_second_value;

   xie_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_ready   (req_ready),
      .instr      (instr),
      .down_valid (dec_valid),
      .down_ready (asm_ready),
      .info       (dec_info)
   );

   xie_assemble u_assemble (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (dec_valid),
      .up_ready   (asm_ready),
      .dec        (dec_info),
      .down_valid (asm_valid),
      .down_ready (pack_ready),
      .info       (asm_info)
   );

   xie_pack u_pack (
      .clock           (clock),
      .reset           (reset),
      .up_valid        (asm_valid),
      .up_ready        (pack_ready),
      .asm_info        (asm_info),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_bytes  (rsp_code_bytes),
      .rsp_code_length (rsp_code_length),
      .rsp_status      (rsp_status)
   );

endmodule

// File: hdl/xie_checker.sv
// ----------------------------------------------------------------------------
// x86 instruction encoder port checker
// Concurrent checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "x86_instruction_encoder_defines.svh"

module xie_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [47:0]        rsp_code_bytes,
   input logic [2:0]         rsp_code_length,
   input logic               rsp_status
);

   // The pipeline is empty straight after reset.
   `XIE_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // A stalled result keeps every field until its transfer.
   `XIE_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_code_bytes) && $stable(rsp_code_length) && $stable(rsp_status))

   // An invalid result carries no bytes at all.
   `XIE_ASSERT_IMPLY(a_invalid_empty, clock, reset, rsp_valid && rsp_status,
      rsp_code_length == 3'd0 && rsp_code_bytes == 48'h0)

   // A valid encoding has one to six bytes, with the top two bytes zero below five.
   `XIE_ASSERT_IMPLY(a_valid_length, clock, reset, rsp_valid && !rsp_status,
      rsp_code_length != 3'd0 && rsp_code_length <= 3'd6 &&
      (rsp_code_length >= 3'd5 || rsp_code_bytes[47:32] == 16'h0))

endmodule

bind x86_instruction_encoder xie_checker u_checker (.*);

// File: bench/tb_x86_instruction_encoder.sv
// ----------------------------------------------------------------------------
// x86 instruction encoder testbench
// Sends instructions to the encoder and checks every encoded transfer against
// a predictor of the x86-64 subset. A directed set covers the opcodes, the
// operand extremes and the rejected combinations. Random traffic then mixes
// mostly well-formed instructions with noise, with random stalls on both
// channels, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_x86_instruction_encoder;
   import xie_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE_CYCLES = 8;

   // x86 register numbers used by the directed instructions.
   localparam logic [3:0] RAX = 4'd0;
   localparam logic [3:0] RCX = 4'd1;
   localparam logic [3:0] RBX = 4'd3;
   localparam logic [3:0] RSP = 4'd4;
   localparam logic [3:0] RBP = 4'd5;
   localparam logic [3:0] RSI = 4'd6;
   localparam logic [3:0] RDI = 4'd7;
   localparam logic [3:0] R8  = 4'd8;
   localparam logic [3:0] R9  = 4'd9;
   localparam logic [3:0] R10 = 4'd10;
   localparam logic [3:0] R11 = 4'd11;
   localparam logic [3:0] R12 = 4'd12;
   localparam logic [3:0] R13 = 4'd13;
   localparam logic [3:0] R14 = 4'd14;
   localparam logic [3:0] R15 = 4'd15;

   // An opcode that the encoder does not know.
   localparam logic [4:0] OP_UNDEFINED = 5'd31;

   // An r/m field of this value calls for a SIB byte, which is not supported.
   localparam logic [2:0] RM_SIB = 3'd4;

   typedef struct packed {
      logic [47:0] code_bytes;
      logic [2:0]  code_length;
      logic        status;
   } encoding_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [4:0]         req_type = '0;
   logic [1:0]         req_first_kind = '0;
   logic [3:0]         req_first_reg = '0;
   logic signed [7:0]  req_first_disp = '0;
   logic signed [31:0] req_first_value = '0;
   logic [1:0]         req_second_kind = '0;
   logic [3:0]         req_second_reg = '0;
   logic signed [7:0]  req_second_disp = '0;
   logic signed [31:0] req_second_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [47:0]        rsp_code_bytes;
   logic [2:0]         rsp_code_length;
   logic               rsp_status;

   encoding_type pending_codes [$];
   int unsigned  instrs_sent = 0;
   int unsigned  results_seen = 0;
   int unsigned  invalid_seen = 0;
   int unsigned  mismatches = 0;
   int unsigned  cycle_count = 0;
   int           hold_off_len = 0;
   bit           sender_gaps = 1'b0;
   bit           sink_gaps = 1'b0;

   x86_instruction_encoder uut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_codes.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Expected encoding of one instruction; status set and no bytes when rejected.
   function automatic encoding_type encode_instr(input instr_type ins);
      logic [7:0]   b [6];
      int           n;
      logic         ok;
      logic [7:0]   load_op;
      logic [7:0]   store_op;
      logic [2:0]   ext;
      logic [31:0]  rel32;
      longint       rel8;
      encoding_type code;
      foreach (b[k]) b[k] = 8'h00;
      n = 0;
      ok = 1'b1;
      load_op = BYTE_ADD_LOAD;
      store_op = BYTE_ADD_STORE;
      ext = EXT_ADD;
      case (ins.op)
         OP_ADD, OP_SUB, OP_CMP: begin
            if (ins.op == OP_SUB) begin
               load_op = BYTE_SUB_LOAD;
               store_op = BYTE_SUB_STORE;
               ext = EXT_SUB;
            end else if (ins.op == OP_CMP) begin
               load_op = BYTE_CMP_LOAD;
               store_op = BYTE_CMP_STORE;
               ext = EXT_CMP;
            end
            if (ins.first_kind != KIND_REG) begin
               ok = 1'b0;
            end else if (ins.second_kind == KIND_MEM) begin
               if (ins.second_reg[2:0] == RM_SIB) begin
                  ok = 1'b0;
               end else begin
                  b[0] = BYTE_REX_W | {5'b0, ins.first_reg[3], 1'b0, ins.second_reg[3]};
                  b[1] = load_op;
                  b[2] = {MOD_DISP8, ins.first_reg[2:0], ins.second_reg[2:0]};
                  b[3] = ins.second_disp;
                  n = 4;
               end
            end else if (ins.second_kind == KIND_IMM) begin
               // Only a non-negative imm8 fits the sign-extended form.
               if (ins.second_value[7]) begin
                  ok = 1'b0;
               end else begin
                  b[0] = BYTE_REX_W | {7'b0, ins.first_reg[3]};
                  b[1] = BYTE_ALU_IMM8;
                  b[2] = {MOD_REG, ext, ins.first_reg[2:0]};
                  b[3] = ins.second_value[7:0];
                  n = 4;
               end
            end else if (ins.second_kind == KIND_REG) begin
               b[0] = BYTE_REX_W | {5'b0, ins.second_reg[3], 1'b0, ins.first_reg[3]};
               b[1] = store_op;
               b[2] = {MOD_REG, ins.second_reg[2:0], ins.first_reg[2:0]};
               n = 3;
            end else begin
               ok = 1'b0;
            end
         end
         OP_LEAVE: begin
            b[0] = BYTE_LEAVE;
            n = 1;
         end
         OP_MOV: begin
            if (ins.first_kind != KIND_REG && ins.first_kind != KIND_MEM) begin
               ok = 1'b0;
            end else if (ins.first_kind == KIND_MEM &&
                         (ins.second_kind != KIND_REG || ins.first_reg[2:0] == RM_SIB)) begin
               ok = 1'b0;
            end else if (ins.second_kind == KIND_MEM) begin
               if (ins.second_reg[2:0] == RM_SIB || ins.second_disp == -8'sd128 ||
                   ins.second_disp == 8'sd127) begin
                  ok = 1'b0;
               end else begin
                  b[0] = BYTE_REX_W | {5'b0, ins.first_reg[3], 1'b0, ins.second_reg[3]};
                  b[1] = BYTE_MOV_LOAD;
                  b[2] = {MOD_DISP8, ins.first_reg[2:0], ins.second_reg[2:0]};
                  b[3] = ins.second_disp;
                  n = 4;
               end
            end else if (ins.second_kind == KIND_IMM) begin
               if (ins.first_reg[3]) begin
                  b[0] = BYTE_REX_B;
                  n = 1;
               end
               b[n]     = BYTE_MOV_IMM + {5'b0, ins.first_reg[2:0]};
               b[n + 1] = ins.second_value[7:0];
               b[n + 2] = ins.second_value[15:8];
               b[n + 3] = ins.second_value[23:16];
               b[n + 4] = ins.second_value[31:24];
               n = n + 5;
            end else if (ins.second_kind == KIND_REG) begin
               b[0] = BYTE_REX_W | {5'b0, ins.second_reg[3], 1'b0, ins.first_reg[3]};
               b[1] = BYTE_MOV_STORE;
               b[2] = {(ins.first_kind == KIND_MEM) ? MOD_DISP8 : MOD_REG,
                       ins.second_reg[2:0], ins.first_reg[2:0]};
               n = 3;
               if (ins.first_kind == KIND_MEM) begin
                  b[3] = ins.first_disp;
                  n = 4;
               end
            end else begin
               ok = 1'b0;
            end
         end
         OP_POP, OP_PUSH: begin
            if (ins.first_kind != KIND_REG) begin
               ok = 1'b0;
            end else begin
               if (ins.first_reg[3]) begin
                  b[0] = BYTE_REX_B;
                  n = 1;
               end
               b[n] = ((ins.op == OP_POP) ? BYTE_POP : BYTE_PUSH) + {5'b0, ins.first_reg[2:0]};
               n = n + 1;
            end
         end
         OP_RET: begin
            b[0] = BYTE_RET;
            n = 1;
         end
         OP_CALL: begin
            if (ins.first_kind != KIND_OFF) begin
               ok = 1'b0;
            end else begin
               rel32 = ins.first_value - 32'd5;
               b[0] = BYTE_CALL;
               b[1] = rel32[7:0];
               b[2] = rel32[15:8];
               b[3] = rel32[23:16];
               b[4] = rel32[31:24];
               n = 5;
            end
         end
         OP_JE, OP_JMP: begin
            rel8 = longint'($signed(ins.first_value)) - 64'sd2;
            if (ins.first_kind != KIND_OFF || rel8 < -128 || rel8 > 127) begin
               ok = 1'b0;
            end else begin
               b[0] = (ins.op == OP_JE) ? BYTE_JE : BYTE_JMP;
               b[1] = rel8[7:0];
               n = 2;
            end
         end
         OP_SETE, OP_SETNE, OP_SETL, OP_SETG, OP_SETLE, OP_SETGE: begin
            if (ins.first_kind != KIND_REG) begin
               ok = 1'b0;
            end else begin
               // A bare REX is needed to reach spl, bpl, sil and dil.
               if (ins.first_reg >= RSP) begin
                  b[0] = ins.first_reg[3] ? BYTE_REX_B : BYTE_REX;
                  n = 1;
               end
               b[n] = BYTE_TWO_BYTE;
               case (ins.op)
                  OP_SETE:  b[n + 1] = 8'h94;
                  OP_SETNE: b[n + 1] = 8'h95;
                  OP_SETL:  b[n + 1] = 8'h9c;
                  OP_SETG:  b[n + 1] = 8'h9f;
                  OP_SETLE: b[n + 1] = 8'h9e;
                  default:  b[n + 1] = 8'h9d;
               endcase
               b[n + 2] = {MOD_REG, 3'b000, ins.first_reg[2:0]};
               n = n + 3;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      if (!ok) begin
         code = '{code_bytes: 48'h0, code_length: 3'd0, status: 1'b1};
      end else begin
         code.code_bytes = {b[5], b[4], b[3], b[2], b[1], b[0]};
         code.code_length = 3'(n);
         code.status = 1'b0;
      end
      return code;
   endfunction

   function automatic instr_type make_instr(input logic [4:0] op,
                                            input logic [1:0] k1, input logic [3:0] r1,
                                            input logic [7:0] d1, input logic [31:0] v1,
                                            input logic [1:0] k2, input logic [3:0] r2,
                                            input logic [7:0] d2, input logic [31:0] v2);
      instr_type ins;
      ins.op = op;
      ins.first_kind = k1;
      ins.first_reg = r1;
      ins.first_disp = d1;
      ins.first_value = v1;
      ins.second_kind = k2;
      ins.second_reg = r2;
      ins.second_disp = d2;
      ins.second_value = v2;
      return ins;
   endfunction

   function automatic logic [1:0] pick_source_kind();
      case ($urandom_range(0, 2))
         0:       return KIND_REG;
         1:       return KIND_IMM;
         default: return KIND_MEM;
      endcase
   endfunction

   // Mostly well-formed instructions with random content; the rest is noise.
   function automatic instr_type random_instr();
      instr_type ins;
      ins.op = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(17, 31))
                                             : 5'($urandom_range(0, 16));
      ins.first_kind = 2'($urandom);
      ins.first_reg = 4'($urandom);
      ins.first_disp = 8'($urandom);
      ins.first_value = $urandom;
      ins.second_kind = 2'($urandom);
      ins.second_reg = 4'($urandom);
      ins.second_disp = 8'($urandom);
      ins.second_value = $urandom;
      if ($urandom_range(0, 7) != 0) begin
         case (ins.op)
            OP_ADD, OP_SUB, OP_CMP: begin
               ins.first_kind = KIND_REG;
               ins.second_kind = pick_source_kind();
               if ($urandom_range(0, 3) != 0) ins.second_value[7] = 1'b0;
            end
            OP_MOV: begin
               ins.first_kind = $urandom_range(0, 1) ? KIND_MEM : KIND_REG;
               ins.second_kind = (ins.first_kind == KIND_MEM) ? KIND_REG : pick_source_kind();
            end
            OP_POP, OP_PUSH, OP_SETE, OP_SETNE, OP_SETL, OP_SETG, OP_SETLE, OP_SETGE: begin
               ins.first_kind = KIND_REG;
            end
            OP_CALL: begin
               ins.first_kind = KIND_OFF;
            end
            OP_JE, OP_JMP: begin
               ins.first_kind = KIND_OFF;
               // Keep most offsets within or just outside the short branch range.
               if ($urandom_range(0, 3) != 0) ins.first_value = $urandom_range(0, 259) - 130;
            end
            default: ;
         endcase
      end
      return ins;
   endfunction

   task automatic drive_fields(input instr_type ins);
      req_type <= ins.op;
      req_first_kind <= ins.first_kind;
      req_first_reg <= ins.first_reg;
      req_first_disp <= ins.first_disp;
      req_first_value <= ins.first_value;
      req_second_kind <= ins.second_kind;
      req_second_reg <= ins.second_reg;
      req_second_disp <= ins.second_disp;
      req_second_value <= ins.second_value;
   endtask

   // Called at a rising edge; returns at the edge of the transfer with valid still high.
   task automatic send_instr(input instr_type ins);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         drive_fields(random_instr());
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      drive_fields(ins);
      do @(posedge clock); while (!req_ready);
      pending_codes.push_back(encode_instr(ins));
      instrs_sent++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input int unsigned index, input string field,
                                  input logic [47:0] got, input logic [47:0] want);
      $display("ERROR: result %0d %s: got %h, expected %h", index, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : result_check
      encoding_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codes.size() == 0) begin
            report_mismatch(results_seen, "transfer with nothing expected", rsp_code_bytes,
                            48'h0);
         end else begin
            want = pending_codes.pop_front();
            if (want.status) invalid_seen++;
            if (rsp_code_bytes !== want.code_bytes)
               report_mismatch(results_seen, "code_bytes", rsp_code_bytes, want.code_bytes);
            if (rsp_code_length !== want.code_length)
               report_mismatch(results_seen, "code_length", 48'(rsp_code_length),
                               48'(want.code_length));
            if (rsp_status !== want.status)
               report_mismatch(results_seen, "status", 48'(rsp_status), 48'(want.status));
         end
         results_seen++;
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   initial begin : result_sink
      int stall;
      forever begin
         @(posedge clock);
         if (hold_off_len != 0) begin
            stall = hold_off_len;
            hold_off_len = 0;
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic test_directed();
      // ALU forms, including the largest imm8 and the first one that does not fit.
      send_instr(make_instr(OP_ADD, KIND_REG, RAX, 8'h00, 32'h0, KIND_MEM, RBX, 8'h7f, 32'h0));
      send_instr(make_instr(OP_SUB, KIND_REG, R15, 8'hff, 32'hffffffff,
                            KIND_IMM, RAX, 8'h00, 32'hffffff7f));
      send_instr(make_instr(OP_CMP, KIND_REG, R9, 8'h00, 32'h0, KIND_REG, R10, 8'h00, 32'h0));
      send_instr(make_instr(OP_ADD, KIND_REG, RCX, 8'h00, 32'h0, KIND_IMM, RAX, 8'h00, 32'h80));
      send_instr(make_instr(OP_SUB, KIND_REG, RBX, 8'h00, 32'h0, KIND_MEM, R12, 8'h80, 32'h0));
      send_instr(make_instr(OP_LEAVE, KIND_OFF, R15, 8'hff, 32'hffffffff,
                            KIND_OFF, R15, 8'hff, 32'hffffffff));
      send_instr(make_instr(OP_RET, KIND_IMM, RAX, 8'h00, 32'h0, KIND_IMM, RAX, 8'h00, 32'h0));
      // Loads at the edge of the allowed displacement, and just beyond it.
      send_instr(make_instr(OP_MOV, KIND_REG, RSI, 8'h00, 32'h0, KIND_MEM, R13, 8'h81, 32'h0));
      send_instr(make_instr(OP_MOV, KIND_REG, RSI, 8'h00, 32'h0, KIND_MEM, RBP, 8'h7f, 32'h0));
      send_instr(make_instr(OP_MOV, KIND_REG, RDI, 8'h00, 32'h0, KIND_MEM, RBX, 8'h80, 32'h0));
      send_instr(make_instr(OP_MOV, KIND_REG, R11, 8'h00, 32'h0,
                            KIND_IMM, RAX, 8'h00, 32'h80000000));
      send_instr(make_instr(OP_MOV, KIND_MEM, R14, 8'h80, 32'h0, KIND_REG, R15, 8'h00, 32'h0));
      send_instr(make_instr(OP_MOV, KIND_MEM, RAX, 8'h01, 32'h0, KIND_IMM, RAX, 8'h00, 32'h5));
      send_instr(make_instr(OP_MOV, KIND_MEM, RSP, 8'h00, 32'h0, KIND_REG, RAX, 8'h00, 32'h0));
      send_instr(make_instr(OP_POP, KIND_REG, R15, 8'h00, 32'h0, KIND_REG, RAX, 8'h00, 32'h0));
      send_instr(make_instr(OP_PUSH, KIND_REG, RAX, 8'h00, 32'h0, KIND_REG, RAX, 8'h00, 32'h0));
      send_instr(make_instr(OP_PUSH, KIND_IMM, RAX, 8'h00, 32'h0, KIND_REG, RAX, 8'h00, 32'h0));
      // Call offset whose rel32 wraps past the sign boundary.
      send_instr(make_instr(OP_CALL, KIND_OFF, RAX, 8'h00, 32'h80000004,
                            KIND_REG, RAX, 8'h00, 32'h0));
      // Short branches at both ends of rel8 and one step outside each.
      send_instr(make_instr(OP_JE, KIND_OFF, RAX, 8'h00, 32'd129, KIND_REG, RAX, 8'h00, 32'h0));
      send_instr(make_instr(OP_JMP, KIND_OFF, RAX, 8'h00, -32'sd126,
                            KIND_REG, RAX, 8'h00, 32'h0));
      send_instr(make_instr(OP_JE, KIND_OFF, RAX, 8'h00, 32'd130, KIND_REG, RAX, 8'h00, 32'h0));
      send_instr(make_instr(OP_JMP, KIND_OFF, RAX, 8'h00, -32'sd127,
                            KIND_REG, RAX, 8'h00, 32'h0));
      send_instr(make_instr(OP_SETE, KIND_REG, RAX, 8'h00, 32'h0, KIND_REG, RAX, 8'h00, 32'h0));
      send_instr(make_instr(OP_SETNE, KIND_REG, RSP, 8'h00, 32'h0, KIND_REG, RAX, 8'h00, 32'h0));
      send_instr(make_instr(OP_SETL, KIND_REG, R8, 8'h00, 32'h0, KIND_REG, RAX, 8'h00, 32'h0));
      send_instr(make_instr(OP_SETG, KIND_REG, R15, 8'h00, 32'h0, KIND_REG, RAX, 8'h00, 32'h0));
      send_instr(make_instr(OP_SETLE, KIND_REG, RDI, 8'h00, 32'h0, KIND_REG, RAX, 8'h00, 32'h0));
      send_instr(make_instr(OP_SETGE, KIND_REG, R12, 8'h00, 32'h0, KIND_REG, RAX, 8'h00, 32'h0));
      send_instr(make_instr(OP_UNDEFINED, KIND_REG, RAX, 8'h00, 32'h0,
                            KIND_REG, RAX, 8'h00, 32'h0));
      wait_drain();
   endtask

   task automatic test_random_traffic(input int count);
      for (int k = 0; k < count; k++) send_instr(random_instr());
   endtask

   // The receiver holds off while instructions keep coming, so the pipeline
   // fills and req_ready must fall until the stall clears.
   task automatic test_backpressure();
      hold_off_len = 60;
      for (int k = 0; k < 24; k++) send_instr(random_instr());
      wait_drain();
   endtask

   // Short bursts with the sender waiting for every result before resuming.
   task automatic test_pause_and_resume();
      for (int k = 0; k < 10; k++) begin
         test_random_traffic($urandom_range(5, 15));
         wait_drain();
      end
   endtask

   initial begin : main_sequence
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      sender_gaps = 1'b1;
      sink_gaps = 1'b1;
      test_directed();
      test_random_traffic(600);
      test_backpressure();
      sender_gaps = 1'b0;
      sink_gaps = 1'b0;
      test_random_traffic(250);
      sender_gaps = 1'b1;
      sink_gaps = 1'b1;
      test_pause_and_resume();
      test_random_traffic(450);
      sender_gaps = 1'b0;
      sink_gaps = 1'b0;
      test_random_traffic(200);
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Encoded %0d instructions over every opcode and operand kind; %0d rejected.",
               instrs_sent, invalid_seen);
      $display("Checked %0d transfers in %0d cycles under stalls, a hold-off and a drain pause.",
               results_seen, cycle_count);
      if (mismatches == 0 && pending_codes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: x86_instruction_encoder.f
+incdir+hdl
hdl/xie_pkg.sv
hdl/xie_decode.sv
hdl/xie_assemble.sv
hdl/xie_pack.sv
hdl/x86_instruction_encoder.sv
hdl/xie_checker.sv
bench/tb_x86_instruction_encoder.sv
